// ===== rtl/core/sntp_pkg.sv =====
// sntp_pkg: shared types, register indexes and constants of the sntp poll controller
// no dependencies
`timescale 1ns / 1ps

package sntp_pkg;

   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [15:0] SNTP_MIN_LEN       = 16'(4 + 3 * 4 + 4 * 8);
   localparam logic [31:0] EPOCH_1900_1970    = 32'(64'd86400 * (64'd365 * 64'd70 + 64'd17));
   localparam logic [31:0] RESET_POLL_INTERVAL = 32'(60 * 60 * 1000);
   localparam logic [31:0] RESET_FIRST_DELAY   = 32'(2 * 60 * 1000);
   localparam logic [31:0] RESET_TIMEOUT       = 32'd1000;
   localparam logic [3:0]  RESET_TRIES         = 4'd3;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_KICK  = 2'd1,
      KIND_REPLY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_ACCEPTED  = 3'd1,
      ST_WRONG_SRC = 3'd2,
      ST_SHORT     = 3'd3,
      ST_VERSION   = 3'd4,
      ST_MODE      = 3'd5,
      ST_UNSYNC    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_INITIAL = 2'd0,
      PH_REPLY   = 2'd1,
      PH_DOZE    = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SERVER_IP      = 3'd0,
      REG_FIRST_DELAY    = 3'd1,
      REG_POLL_INTERVAL  = 3'd2,
      REG_REPLY_TIMEOUT  = 3'd3,
      REG_MAX_TRIES      = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] server_ip;
      logic [31:0] first_poll_delay_ms;
      logic [31:0] poll_interval_ms;
      logic [31:0] reply_timeout_ms;
      logic [3:0]  max_tries;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] src_ip;
      logic [15:0] udp_len;
      logic [7:0]  mode_byte;
      logic [7:0]  stratum;
      logic [31:0] xmt_seconds;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  status;
      logic [31:0] time_value;
   } chk_type;

endpackage

// ===== rtl/core/sntp_if.sv =====
// sntp_if: handshake channel interfaces for request items, result items and csr writes
// depends on sntp_pkg
`timescale 1ns / 1ps

interface sntp_req_if
   import sntp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] src_ip;
   logic [15:0] udp_len;
   logic [7:0]  mode_byte;
   logic [7:0]  stratum;
   logic [31:0] xmt_seconds;

   modport source (output valid, kind, src_ip, udp_len, mode_byte, stratum, xmt_seconds,
                   input ready);
   modport sink (input valid, kind, src_ip, udp_len, mode_byte, stratum, xmt_seconds,
                 output ready);
endinterface

interface sntp_rsp_if
   import sntp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   logic        send_request;
   logic        set_time;
   logic [31:0] time_value;
   logic [2:0]  reply_status;

   modport source (output valid, send_request, set_time, time_value, reply_status,
                   input ready);
   modport sink (input valid, send_request, set_time, time_value, reply_status,
                 output ready);
endinterface

interface sntp_csr_if
   import sntp_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [31:0]          wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/core/sntp_csr_regs.sv =====
// sntp_csr_regs: configuration registers of the poll controller
// depends on sntp_pkg
`timescale 1ns / 1ps

module sntp_csr_regs
   import sntp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [31:0]          wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_SERVER_IP:     cfg_in.server_ip           = wr_data;
            REG_FIRST_DELAY:   cfg_in.first_poll_delay_ms = wr_data;
            REG_POLL_INTERVAL: cfg_in.poll_interval_ms    = wr_data;
            REG_REPLY_TIMEOUT: cfg_in.reply_timeout_ms    = wr_data;
            REG_MAX_TRIES:     cfg_in.max_tries           = wr_data[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_ip           <= '0;
         cfg_ff.first_poll_delay_ms <= RESET_FIRST_DELAY;
         cfg_ff.poll_interval_ms    <= RESET_POLL_INTERVAL;
         cfg_ff.reply_timeout_ms    <= RESET_TIMEOUT;
         cfg_ff.max_tries           <= RESET_TRIES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/sntp_reply_chk.sv =====
// sntp_reply_chk: header checks on a received reply and the unix time it carries
// depends on sntp_pkg
`timescale 1ns / 1ps

module sntp_reply_chk
   import sntp_pkg::*;
(
   input  req_type     item,
   input  logic [31:0] server_ip,
   output chk_type     chk
);

   logic [2:0]  version;
   logic [1:0]  leap;
   logic [2:0]  mode;
   logic [31:0] unix_time;
   status_type  status;

   assign version   = item.mode_byte[5:3];
   assign leap      = item.mode_byte[7:6];
   assign mode      = item.mode_byte[2:0];
   assign unix_time = item.xmt_seconds - EPOCH_1900_1970;

   always_comb begin
      if (item.kind != KIND_REPLY) begin
         status = ST_NONE;
      end else if (item.src_ip != server_ip) begin
         status = ST_WRONG_SRC;
      end else if (item.udp_len < SNTP_MIN_LEN) begin
         status = ST_SHORT;
      end else if (version == 3'd0 || version > 3'd3) begin
         status = ST_VERSION;
      end else if (mode >= 3'd6 || mode == 3'd3) begin
         status = ST_MODE;
      end else if (leap == 2'd3 || unix_time == '0 || item.stratum == '0) begin
         status = ST_UNSYNC;
      end else begin
         status = ST_ACCEPTED;
      end
   end

   assign chk.accepted   = (status == ST_ACCEPTED);
   assign chk.status     = status;
   assign chk.time_value = (status == ST_ACCEPTED) ? unix_time : '0;

endmodule

// ===== rtl/core/sntp_poll_seq.sv =====
// sntp_poll_seq: poll round sequencer with wait counter, try count and pending kick
// depends on sntp_pkg
`timescale 1ns / 1ps

module sntp_poll_seq
   import sntp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] kind,
   input  logic       reply_ok,
   input  cfg_type    cfg,
   output logic       send_request
);

   phase_type   phase_ff, phase_in;
   logic [31:0] wait_ff, wait_in;
   logic [3:0]  tries_ff, tries_in;
   logic        kick_ff, kick_in;

   logic [31:0] wait_inc;
   logic        server_ok;
   logic        do_start;
   logic        do_end;
   logic        start;
   logic        send_retry;

   // saturating tick count
   assign wait_inc  = (wait_ff == '1) ? wait_ff : wait_ff + 32'd1;
   assign server_ok = (cfg.server_ip != '0) && (cfg.max_tries != '0);

   always_comb begin
      do_start   = 1'b0;
      do_end     = 1'b0;
      send_retry = 1'b0;
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      tries_in   = tries_ff;
      kick_in    = kick_ff;
      case (kind)
         KIND_TICK: begin
            wait_in = wait_inc;
            case (phase_ff)
               PH_INITIAL: do_start = (wait_inc >= cfg.first_poll_delay_ms);
               PH_REPLY: begin
                  if (wait_inc >= cfg.reply_timeout_ms) begin
                     if (tries_ff < cfg.max_tries) begin
                        tries_in   = tries_ff + 4'd1;
                        wait_in    = '0;
                        send_retry = 1'b1;
                     end else begin
                        do_end = 1'b1;
                     end
                  end
               end
               default: do_start = (wait_inc >= cfg.poll_interval_ms);
            endcase
         end
         KIND_KICK: begin
            kick_in  = 1'b1;
            do_start = (phase_ff != PH_REPLY);
         end
         KIND_REPLY: do_end = reply_ok && (phase_ff == PH_REPLY);
         default: ;
      endcase

      if (do_end) begin
         phase_in = PH_DOZE;
         wait_in  = '0;
      end

      // a pending kick restarts the round as soon as it ends
      start = do_start || (do_end && kick_ff);
      if (start) begin
         kick_in = 1'b0;
         wait_in = '0;
         if (server_ok) begin
            tries_in = 4'd1;
            phase_in = PH_REPLY;
         end else begin
            phase_in = PH_DOZE;
         end
      end
   end

   assign send_request = send_retry || (start && server_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INITIAL;
         wait_ff  <= '0;
         tries_ff <= '0;
         kick_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         tries_ff <= tries_in;
         kick_ff  <= kick_in;
      end
   end

endmodule

// ===== rtl/core/sntp_client_poll_controller.sv =====
// sntp_client_poll_controller: top level, input register, sequencer, checks, result register
// depends on sntp_pkg, sntp_if, sntp_csr_regs, sntp_reply_chk, sntp_poll_seq
//
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | kind, src_ip, udp_len, mode_byte, stratum, xmt_seconds
//  rsp     | out | valid / ready   | send_request, set_time, time_value, reply_status
//  csr     | in  | valid / ready   | index, wdata (ready always high)
//
// one item per cycle sustained while no result stalls; an item is first registered in the
// input register, then checked and applied to the sequencer state while its result is
// written to the result register
// a stalled result holds the pipe; the input register still takes an item when it
// is empty or moving on
// synchronous reset clears pipe valids, sequencer state and loads register defaults
`timescale 1ns / 1ps

module sntp_client_poll_controller
   import sntp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   sntp_req_if.sink   req,
   sntp_rsp_if.source rsp,
   sntp_csr_if.sink   csr
);

   cfg_type cfg;
   req_type item_ff, item_in;
   logic    item_valid_ff, item_valid_in;
   chk_type chk;
   logic    send_request;
   logic    advance;
   logic    req_fire;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        send_ff;
   logic        set_ff;
   logic [31:0] time_ff;
   logic [2:0]  status_ff;

   assign csr.ready = 1'b1;

   sntp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.wdata),
      .cfg      (cfg)
   );

   // item moves to the result register when that one is free or draining
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   assign item_in.kind        = req.kind;
   assign item_in.src_ip      = req.src_ip;
   assign item_in.udp_len     = req.udp_len;
   assign item_in.mode_byte   = req.mode_byte;
   assign item_in.stratum     = req.stratum;
   assign item_in.xmt_seconds = req.xmt_seconds;

   assign item_valid_in = req_fire || (item_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   sntp_reply_chk u_chk (
      .item      (item_ff),
      .server_ip (cfg.server_ip),
      .chk       (chk)
   );

   sntp_poll_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .kind         (item_ff.kind),
      .reply_ok     (chk.accepted),
      .cfg          (cfg),
      .send_request (send_request)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         send_ff   <= send_request;
         set_ff    <= chk.accepted;
         time_ff   <= chk.time_value;
         status_ff <= chk.status;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.send_request = send_ff;
   assign rsp.set_time     = set_ff;
   assign rsp.time_value   = time_ff;
   assign rsp.reply_status = status_ff;

   // set_time goes with an accepted status and nothing else
   a_set_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (set_ff == (status_ff == ST_ACCEPTED)))
      else $error("set_time disagrees with reply_status");

   // a time value only travels with set_time
   a_time_only_when_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !set_ff) |-> (time_ff == '0))
      else $error("time_value nonzero without set_time");

   // an item in the input register is not dropped while the result side stalls
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> item_valid_ff)
      else $error("input register lost an item");

   // a result register that is taken with no item behind it empties
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp.ready && !advance) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule
